// ----- sv/rmbd_pkg.sv -----
`timescale 1ns / 1ps

package rmbd_pkg;

	localparam int NEST_OUT_W = 4;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_LEN,
		PH_LEN_LF,
		PH_LINE,
		PH_LINE_LF,
		PH_BULK,
		PH_BULK_T1,
		PH_BULK_T2
	} phase_t;

	typedef enum logic [1:0] {
		TT_SIMPLE,
		TT_BULK,
		TT_ARRAY
	} token_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_BAD_CHAR,
		ERR_NEST,
		ERR_LEN_OVF
	} err_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} stk_cmd_t;

	typedef struct packed {
		logic full;
		logic pop_empty;
	} stk_stat_t;

endpackage

// ----- sv/resp_message_boundary_detector.sv -----
`timescale 1ns / 1ps

// RESP request framer: one byte per transaction in, one result per byte out.
// input channel: data_byte with in_valid / in_ready
// output channel: message_done, error_code, payload_byte, nesting_level with
//   out_valid / out_ready
// every byte produces exactly one result, in order
// throughput: one byte per cycle while out_ready holds; the array stack pops any number
//   of levels at once through a priority find over per-level last-element flags
// the byte sits in an input register; parsing runs between it and the
//   result register, so a new byte is taken while a result waits
// when out_ready is low the result holds, the input register still takes
//   one more byte, then in_ready drops until the result is taken
// an error reports its code, abandons the message and returns the parser
//   to the type byte with no arrays open
// reset: parser waits for a type byte, stack empty, both channels empty
module resp_message_boundary_detector #(
	parameter int MAX_NESTING = 8,
	parameter int LENGTH_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      data_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            message_done,
	output logic [1:0]                      error_code,
	output logic                            payload_byte,
	output logic [rmbd_pkg::NEST_OUT_W-1:0] nesting_level
);

	localparam int LW = $clog2(MAX_NESTING + 1);
	localparam int NestW = rmbd_pkg::NEST_OUT_W;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	// parser state
	rmbd_pkg::phase_t       phase_q, phase_d;
	rmbd_pkg::token_t       tt_q, tt_d;
	logic [LENGTH_BITS-1:0] acc_q, acc_d;
	logic                   neg_q, neg_d;
	logic                   seen_q, seen_d;
	logic [LENGTH_BITS-1:0] rem_q, rem_d;

	// result register
	logic                   out_valid_q;
	logic                   done_q;
	rmbd_pkg::err_t         err_q;
	logic                   pay_q;
	logic [NestW-1:0]       nest_q;

	rmbd_pkg::err_t         err;
	logic                   done;
	logic                   pay;
	rmbd_pkg::stk_cmd_t     cmd;
	rmbd_pkg::stk_stat_t    stat;
	logic [LW-1:0]          next_level;

	logic                   is_digit;
	logic [LENGTH_BITS+3:0] acc_ext;
	logic [LENGTH_BITS+3:0] acc_next;
	logic                   acc_ovf;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
		end
	end

	// decimal length step: acc * 10 + digit
	assign is_digit = (byte_s1 >= rmbd_pkg::CH_ZERO) && (byte_s1 <= rmbd_pkg::CH_NINE);
	assign acc_ext  = (LENGTH_BITS + 4)'(acc_q);
	assign acc_next = (acc_ext << 3) + (acc_ext << 1) + (LENGTH_BITS + 4)'(byte_s1[3:0]);
	assign acc_ovf  = |acc_next[LENGTH_BITS+3:LENGTH_BITS];

	rmbd_stack #(
		.MAX_NESTING (MAX_NESTING),
		.LENGTH_BITS (LENGTH_BITS)
	) u_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.push_value (acc_q),
		.stat       (stat),
		.next_level (next_level)
	);

	always_comb begin
		phase_d = phase_q;
		tt_d    = tt_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		seen_d  = seen_q;
		rem_d   = rem_q;
		err     = rmbd_pkg::ERR_NONE;
		done    = 1'b0;
		pay     = 1'b0;
		cmd     = '0;

		if (advance) begin
			unique case (phase_q)
				rmbd_pkg::PH_TYPE: begin
					if (byte_s1 == rmbd_pkg::CH_DOLLAR || byte_s1 == rmbd_pkg::CH_STAR) begin
						tt_d = (byte_s1 == rmbd_pkg::CH_DOLLAR) ? rmbd_pkg::TT_BULK
							: rmbd_pkg::TT_ARRAY;
						acc_d   = '0;
						neg_d   = 1'b0;
						seen_d  = 1'b0;
						phase_d = rmbd_pkg::PH_LEN;
					end else begin
						tt_d    = rmbd_pkg::TT_SIMPLE;
						phase_d = (byte_s1 == rmbd_pkg::CH_CR) ? rmbd_pkg::PH_LINE_LF
							: rmbd_pkg::PH_LINE;
					end
				end
				rmbd_pkg::PH_LEN: begin
					priority if (is_digit) begin
						if (acc_ovf) begin
							err = rmbd_pkg::ERR_LEN_OVF;
						end else begin
							acc_d  = acc_next[LENGTH_BITS-1:0];
							seen_d = 1'b1;
						end
					end else if (byte_s1 == rmbd_pkg::CH_MINUS && !seen_q && !neg_q) begin
						neg_d = 1'b1;
					end else if (byte_s1 == rmbd_pkg::CH_CR && seen_q) begin
						phase_d = rmbd_pkg::PH_LEN_LF;
					end else begin
						err = rmbd_pkg::ERR_BAD_CHAR;
					end
				end
				rmbd_pkg::PH_LEN_LF: begin
					if (byte_s1 != rmbd_pkg::CH_LF) begin
						err = rmbd_pkg::ERR_BAD_CHAR;
					end else if (tt_q == rmbd_pkg::TT_BULK) begin
						if (neg_q) begin
							phase_d = rmbd_pkg::PH_TYPE;
							cmd.pop = 1'b1;
							done    = stat.pop_empty;
						end else begin
							rem_d   = acc_q;
							phase_d = (acc_q == '0) ? rmbd_pkg::PH_BULK_T1
								: rmbd_pkg::PH_BULK;
						end
					end else if (neg_q || acc_q == '0) begin
						// null or empty array completes at once
						phase_d = rmbd_pkg::PH_TYPE;
						cmd.pop = 1'b1;
						done    = stat.pop_empty;
					end else if (stat.full) begin
						err = rmbd_pkg::ERR_NEST;
					end else begin
						cmd.push = 1'b1;
						phase_d  = rmbd_pkg::PH_TYPE;
					end
				end
				rmbd_pkg::PH_LINE: begin
					if (byte_s1 == rmbd_pkg::CH_CR) begin
						phase_d = rmbd_pkg::PH_LINE_LF;
					end
				end
				rmbd_pkg::PH_LINE_LF: begin
					if (byte_s1 == rmbd_pkg::CH_LF) begin
						phase_d = rmbd_pkg::PH_TYPE;
						cmd.pop = 1'b1;
						done    = stat.pop_empty;
					end else if (byte_s1 != rmbd_pkg::CH_CR) begin
						phase_d = rmbd_pkg::PH_LINE;
					end
				end
				rmbd_pkg::PH_BULK: begin
					pay = 1'b1;
					if (rem_q != '0) begin
						rem_d = rem_q - LENGTH_BITS'(1);
					end
					if (rem_q <= LENGTH_BITS'(1)) begin
						phase_d = rmbd_pkg::PH_BULK_T1;
					end
				end
				rmbd_pkg::PH_BULK_T1: begin
					phase_d = rmbd_pkg::PH_BULK_T2;
				end
				rmbd_pkg::PH_BULK_T2: begin
					phase_d = rmbd_pkg::PH_TYPE;
					cmd.pop = 1'b1;
					done    = stat.pop_empty;
				end
				default: begin
					phase_d = rmbd_pkg::PH_TYPE;
				end
			endcase

			// abandon the message
			if (err != rmbd_pkg::ERR_NONE) begin
				phase_d   = rmbd_pkg::PH_TYPE;
				tt_d      = rmbd_pkg::TT_SIMPLE;
				acc_d     = '0;
				neg_d     = 1'b0;
				seen_d    = 1'b0;
				rem_d     = '0;
				cmd       = '0;
				cmd.clear = 1'b1;
				done      = 1'b0;
				pay       = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rmbd_pkg::PH_TYPE;
			tt_q    <= rmbd_pkg::TT_SIMPLE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
			rem_q   <= '0;
		end else begin
			phase_q <= phase_d;
			tt_q    <= tt_d;
			acc_q   <= acc_d;
			neg_q   <= neg_d;
			seen_q  <= seen_d;
			rem_q   <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			done_q <= done;
			err_q  <= err;
			pay_q  <= pay;
			nest_q <= NestW'(next_level);
		end
	end

	assign out_valid     = out_valid_q;
	assign message_done  = done_q;
	assign error_code    = err_q;
	assign payload_byte  = pay_q;
	assign nesting_level = nest_q;

endmodule

// ----- sv/rmbd_stack.sv -----
`timescale 1ns / 1ps

module rmbd_stack #(
	parameter int MAX_NESTING = 8,
	parameter int LENGTH_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rmbd_pkg::stk_cmd_t                   cmd,
	input  logic [LENGTH_BITS-1:0]               push_value,
	output rmbd_pkg::stk_stat_t                  stat,
	output logic [$clog2(MAX_NESTING+1)-1:0]     next_level
);

	localparam int LW = $clog2(MAX_NESTING + 1);
	localparam int IW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

	logic [LW-1:0]          level_q;
	logic [LENGTH_BITS-1:0] count_q [MAX_NESTING];
	logic [MAX_NESTING-1:0] one_q;

	logic                   found;
	logic [IW-1:0]          found_idx;
	logic [LENGTH_BITS-1:0] sel_count;

	// highest open level whose count does not run out on this element
	always_comb begin
		found = 1'b0;
		found_idx = '0;
		for (int i = 0; i < MAX_NESTING; i++) begin
			if ((LW'(i) < level_q) && !one_q[i]) begin
				found = 1'b1;
				found_idx = IW'(i);
			end
		end
	end

	assign sel_count = count_q[found_idx];

	assign stat.full = (level_q == LW'(MAX_NESTING));
	assign stat.pop_empty = !found;

	always_comb begin
		priority if (cmd.clear) begin
			next_level = '0;
		end else if (cmd.push) begin
			next_level = level_q + LW'(1);
		end else if (cmd.pop) begin
			next_level = found ? (LW'(found_idx) + LW'(1)) : '0;
		end else begin
			next_level = level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else begin
			level_q <= next_level;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd.clear && cmd.push) begin
			count_q[level_q[IW-1:0]] <= push_value;
			one_q[level_q[IW-1:0]] <= (push_value == LENGTH_BITS'(1));
		end else if (!cmd.clear && cmd.pop && found) begin
			count_q[found_idx] <= sel_count - LENGTH_BITS'(1);
			one_q[found_idx] <= (sel_count == LENGTH_BITS'(2));
		end
	end

endmodule
